/* hw/rtl/bba_pkg.sv */
package bba_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_OUTCOME = 2'd1,
    OP_LOAD    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_WRITE_REQ = 2'd0,
    KIND_FINAL     = 2'd1,
    KIND_LOAD_ACK  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_WRITE_FAIL = 3'd2,
    ST_NO_PENDING = 3'd3,
    ST_PENDING    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FAIL,
    S_EMIT
  } state_t;

  localparam int ID_OUT_W = 9;
  localparam int ADDR_W   = 12;

  typedef struct packed {
    kind_t                 kind;
    logic [ID_OUT_W-1:0]   block_id;
    logic [ADDR_W-1:0]     table_addr;
    logic [7:0]            table_byte;
    status_t               status;
  } res_t;

endpackage

/* hw/rtl/bba_in_if.sv */
interface bba_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       write_ok;
  logic [4:0] load_index;
  logic [7:0] load_value;

  modport source (output valid, output op, output write_ok, output load_index,
                  output load_value, input ready);
  modport sink (input valid, input op, input write_ok, input load_index,
                input load_value, output ready);
endinterface

/* hw/rtl/bba_out_if.sv */
interface bba_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [8:0]  block_id;
  logic [11:0] table_addr;
  logic [7:0]  table_byte;
  logic [2:0]  status;

  modport source (output valid, output kind, output block_id, output table_addr,
                  output table_byte, output status, input ready);
  modport sink (input valid, input kind, input block_id, input table_addr,
                input table_byte, input status, output ready);
endinterface

/* hw/rtl/bitmap_block_allocator.sv */
// Channel   | Dir | Handshake          | Payload
// in_req    | in  | valid/ready        | op, write_ok, load_index, load_value
// out_res   | out | valid/ready        | kind, block_id, table_addr, table_byte, status
// cfg       | in  | cfg_we, no wait    | cfg_wdata = table base address
//
// A scanning allocate reads one bitmap byte per cycle from the bitmap RAM until it finds a
// free bit or passes the last byte. A failed outcome steps through read, write back and emit;
// other requests, an allocate while one is pending among them, go straight to emit.
// After reset a clearing pass writes zero to every one of the BYTES bitmap bytes
// (BYTES = ceil(BLOCK_TOTAL/8)), with in_req.ready low. One request is in flight.
// A result parks in the output register; emit holds while it is full and not taken.
module bitmap_block_allocator #(
  parameter int BLOCK_TOTAL = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [11:0]  cfg_wdata,
  bba_in_if.sink       in_req,
  bba_out_if.source    out_res
);

  localparam int BYTES = (BLOCK_TOTAL + 7) / 8;
  localparam int BA_W  = (BYTES > 1) ? $clog2(BYTES) : 1;
  localparam int ID_W  = BA_W + 3;
  localparam int REM   = BLOCK_TOTAL % 8;
  localparam logic [7:0] TAIL_MASK = (REM == 0) ? 8'hFF : 8'((1 << REM) - 1);
  localparam logic [BA_W-1:0] LAST = BA_W'(BYTES - 1);
  localparam logic [bba_pkg::ID_OUT_W-1:0] NONE_ID = bba_pkg::ID_OUT_W'(BLOCK_TOTAL);

  function automatic logic [2:0] low_zero(input logic [7:0] v);
    logic [2:0] pos;
    pos = '0;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) pos = 3'(i);
    end
    return pos;
  endfunction

  logic [7:0]          bitmap_mem_r [BYTES];
  logic [7:0]          rd_data_r;
  logic [BA_W-1:0]     rd_addr;
  logic                mem_we;
  logic [BA_W-1:0]     mem_waddr;
  logic [7:0]          mem_wdata;

  bba_pkg::state_t     state_r, state_nxt;
  logic [BA_W-1:0]     scan_r, scan_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]     pend_block_r, pend_block_nxt;
  logic [11:0]         base_r;
  bba_pkg::res_t       res_r, res_nxt;
  bba_pkg::res_t       out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                in_fire;
  logic                slot_free;
  logic                load_in_range;
  logic [7:0]          scan_byte;
  logic                scan_found;
  logic [2:0]          scan_bit;
  logic [2:0]          pend_bit;

  assign in_fire       = in_req.valid && in_req.ready;
  assign slot_free     = !out_valid_r || out_res.ready;
  assign load_in_range = 32'(in_req.load_index) < 32'(BYTES);
  assign scan_byte     = rd_data_r | ((scan_r == LAST) ? ~TAIL_MASK : 8'h00);
  assign scan_found    = scan_byte != 8'hFF;
  assign scan_bit      = low_zero(scan_byte);
  assign pend_bit      = pend_block_r[2:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= bitmap_mem_r[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bba_pkg::S_CLEAR: begin
        if (scan_r == LAST) state_nxt = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        if (in_fire) begin
          case (bba_pkg::op_t'(in_req.op))
            bba_pkg::OP_ALLOC: begin
              state_nxt = pend_valid_r ? bba_pkg::S_EMIT : bba_pkg::S_SCAN;
            end
            bba_pkg::OP_OUTCOME: begin
              state_nxt = (pend_valid_r && !in_req.write_ok) ? bba_pkg::S_FAIL
                                                              : bba_pkg::S_EMIT;
            end
            bba_pkg::OP_LOAD: state_nxt = bba_pkg::S_EMIT;
            default: state_nxt = bba_pkg::S_IDLE;
          endcase
        end
      end
      bba_pkg::S_SCAN: begin
        if (scan_found || scan_r == LAST) state_nxt = bba_pkg::S_EMIT;
      end
      bba_pkg::S_FAIL: state_nxt = bba_pkg::S_EMIT;
      bba_pkg::S_EMIT: begin
        if (slot_free) state_nxt = bba_pkg::S_IDLE;
      end
      default: state_nxt = bba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_req.ready   = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = scan_r;
    mem_wdata      = 8'h00;
    rd_addr        = scan_r;
    scan_nxt       = scan_r;
    pend_valid_nxt = pend_valid_r;
    pend_block_nxt = pend_block_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    case (state_r)
      bba_pkg::S_CLEAR: begin
        mem_we   = 1'b1;
        scan_nxt = (scan_r == LAST) ? '0 : scan_r + 1'b1;
      end
      bba_pkg::S_IDLE: begin
        in_req.ready = 1'b1;
        if (in_fire) begin
          case (bba_pkg::op_t'(in_req.op))
            bba_pkg::OP_ALLOC: begin
              if (pend_valid_r) begin
                res_nxt = '{bba_pkg::KIND_FINAL, bba_pkg::ID_OUT_W'(pend_block_r),
                            12'h000, 8'h00, bba_pkg::ST_PENDING};
              end else begin
                rd_addr  = '0;
                scan_nxt = '0;
              end
            end
            bba_pkg::OP_OUTCOME: begin
              if (!pend_valid_r) begin
                res_nxt = '{bba_pkg::KIND_FINAL, NONE_ID, 12'h000, 8'h00,
                            bba_pkg::ST_NO_PENDING};
              end else begin
                pend_valid_nxt = 1'b0;
                if (in_req.write_ok) begin
                  res_nxt = '{bba_pkg::KIND_FINAL, bba_pkg::ID_OUT_W'(pend_block_r),
                              12'h000, 8'h00, bba_pkg::ST_OK};
                end else begin
                  rd_addr = pend_block_r[ID_W-1:3];
                end
              end
            end
            bba_pkg::OP_LOAD: begin
              mem_we    = load_in_range;
              mem_waddr = BA_W'(in_req.load_index);
              mem_wdata = in_req.load_value;
              res_nxt   = '{bba_pkg::KIND_LOAD_ACK, '0,
                            12'(base_r + 12'(in_req.load_index)),
                            in_req.load_value, bba_pkg::ST_OK};
            end
            default: ;
          endcase
        end
      end
      bba_pkg::S_SCAN: begin
        if (scan_found) begin
          mem_we         = 1'b1;
          mem_wdata      = rd_data_r | (8'h01 << scan_bit);
          pend_valid_nxt = 1'b1;
          pend_block_nxt = {scan_r, scan_bit};
          res_nxt        = '{bba_pkg::KIND_WRITE_REQ,
                             bba_pkg::ID_OUT_W'({scan_r, scan_bit}),
                             12'(base_r + 12'(scan_r)),
                             rd_data_r | (8'h01 << scan_bit), bba_pkg::ST_OK};
        end else if (scan_r == LAST) begin
          res_nxt = '{bba_pkg::KIND_FINAL, NONE_ID, 12'h000, 8'h00, bba_pkg::ST_FULL};
        end else begin
          scan_nxt = scan_r + 1'b1;
          rd_addr  = scan_r + 1'b1;
        end
      end
      bba_pkg::S_FAIL: begin
        mem_we    = 1'b1;
        mem_waddr = pend_block_r[ID_W-1:3];
        mem_wdata = rd_data_r & ~(8'h01 << pend_bit);
        res_nxt   = '{bba_pkg::KIND_FINAL, NONE_ID, 12'h000, 8'h00,
                      bba_pkg::ST_WRITE_FAIL};
      end
      bba_pkg::S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bba_pkg::S_CLEAR;
      scan_r       <= '0;
      pend_valid_r <= 1'b0;
      pend_block_r <= '0;
      base_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_block_r <= pend_block_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) base_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.kind       = out_r.kind;
  assign out_res.block_id   = out_r.block_id;
  assign out_res.table_addr = out_r.table_addr;
  assign out_res.table_byte = out_r.table_byte;
  assign out_res.status     = out_r.status;

`ifndef SYNTH
  a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (32'(pend_block_r) < 32'(BLOCK_TOTAL)))
    else $error("pending block beyond block count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_SCAN || state_r == bba_pkg::S_CLEAR) |->
    (32'(scan_r) < 32'(BYTES)))
    else $error("scan pointer beyond bitmap");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == bba_pkg::S_EMIT)
    else $error("result launched outside emit");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_SCAN || state_r == bba_pkg::S_FAIL) |=>
    (state_r != bba_pkg::S_IDLE || $past(state_r) == bba_pkg::S_EMIT ||
     $past(state_r) == bba_pkg::S_SCAN || $past(state_r) == bba_pkg::S_FAIL))
    else $error("request taken while one is in flight");
`endif

endmodule
